>>> rtl/core/gtg_pkg.sv
// gtg_pkg: shared constants, types and the arctangent table for the
// go-to-goal heading controller. No dependencies.
package gtg_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN = 24;
   localparam int CW = 44;   // cordic datapath width
   localparam int ZW = 34;   // angle width, Q2.30 plus headroom

   localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

   typedef enum logic [2:0] {
      REG_GOAL_X = 3'd0,
      REG_GOAL_Y = 3'd1,
      REG_GAIN   = 3'd2,
      REG_SPEED  = 3'd3,
      REG_RADIUS = 3'd4
   } reg_idx_type;

   // per item control travelling with the cordic pipeline
   typedef struct packed {
      logic        near;
      logic [15:0] gain;
      logic [15:0] speed;
      logic signed [15:0] heading;
   } side_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int i);
      logic signed [ZW-1:0] t;
      begin
         unique case (i)
            0: t = 34'sd843314856;  1: t = 34'sd497837829;
            2: t = 34'sd263043836;  3: t = 34'sd133525158;
            4: t = 34'sd67021686;   5: t = 34'sd33543515;
            6: t = 34'sd16775850;   7: t = 34'sd8388437;
            8: t = 34'sd4194282;    9: t = 34'sd2097149;
            10: t = 34'sd1048575;   11: t = 34'sd524287;
            12: t = 34'sd262143;    13: t = 34'sd131071;
            14: t = 34'sd65535;     15: t = 34'sd32767;
            16: t = 34'sd16383;     17: t = 34'sd8191;
            18: t = 34'sd4095;      19: t = 34'sd2047;
            20: t = 34'sd1023;      21: t = 34'sd511;
            22: t = 34'sd255;       23: t = 34'sd127;
            default: t = '0;
         endcase
         return t;
      end
   endfunction

endpackage

>>> rtl/core/go_to_goal_heading_controller_top.sv
// Go-to-goal heading controller top level: front end, cordic, back end.
// Depends on gtg_pkg and gtg_cordic.

// Takes one odometry request per cycle while the output is not stalled and
// returns one command per request, in order. The pipeline is three front-end stages
// (difference, squared distance and normalising shift), one register per
// cordic step, then error wrap, gain multiply and saturation stages. The
// whole pipeline advances when the output register is empty or being taken,
// so back pressure stalls every stage together and nothing is lost.
module go_to_goal_heading_controller_top #(
   parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_heading,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_linear_cmd,
   output logic signed [15:0] rsp_angular_cmd,
   output logic rsp_arrived,
   input  logic csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_write_data
);
   localparam int CW = gtg_pkg::CW;
   localparam int ZW = gtg_pkg::ZW;

   logic advance;
   logic out_valid_ff;

   // configuration registers
   logic signed [31:0] goal_x_ff, goal_y_ff;
   logic [15:0] gain_ff, speed_ff, radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         gain_ff <= 16'd2048;
         speed_ff <= 16'd9830;
         radius_ff <= 16'd6554;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            gtg_pkg::REG_GOAL_X: goal_x_ff <= csr_write_data;
            gtg_pkg::REG_GOAL_Y: goal_y_ff <= csr_write_data;
            gtg_pkg::REG_GAIN:   gain_ff <= csr_write_data[15:0];
            gtg_pkg::REG_SPEED:  speed_ff <= csr_write_data[15:0];
            gtg_pkg::REG_RADIUS: radius_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   assign advance = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   // stage 1: differences
   logic v1_ff;
   logic signed [32:0] dx1_ff, dy1_ff;
   logic signed [15:0] hd1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= req_valid;
      if (advance) begin
         dx1_ff <= 33'(goal_x_ff) - 33'(req_pos_x);
         dy1_ff <= 33'(goal_y_ff) - 33'(req_pos_y);
         hd1_ff <= req_heading;
      end
   end

   // stage 2: magnitudes, squares and leading size
   logic [32:0] ax1, ay1, m1;
   logic small1;
   assign ax1 = dx1_ff[32] ? 33'(-dx1_ff) : 33'(dx1_ff);
   assign ay1 = dy1_ff[32] ? 33'(-dy1_ff) : 33'(dy1_ff);
   assign m1 = (ax1 > ay1) ? ax1 : ay1;
   assign small1 = (ax1 <= 33'(radius_ff)) && (ay1 <= 33'(radius_ff));

   logic v2_ff, small2_ff;
   logic [31:0] sx2_ff, sy2_ff, rr2_ff;
   logic signed [32:0] dx2_ff, dy2_ff;
   logic [32:0] m2_ff;
   logic signed [15:0] hd2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         small2_ff <= small1;
         sx2_ff <= ax1[15:0] * ax1[15:0];
         sy2_ff <= ay1[15:0] * ay1[15:0];
         rr2_ff <= radius_ff * radius_ff;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         m2_ff <= m1;
         hd2_ff <= hd1_ff;
      end
   end

   // stage 3: arrival compare, normalising shift and half-plane turn
   logic near2;
   logic [5:0] lz2;
   logic signed [CW-1:0] xs2, ys2, xr2, yr2;
   logic signed [ZW-1:0] z2;
   assign near2 = small2_ff && ({1'b0, sx2_ff} + {1'b0, sy2_ff} <= {1'b0, rr2_ff});

   // shift so the larger component reaches bit 40
   always_comb begin
      lz2 = 6'd40;
      for (int b = 0; b <= 32; b++) begin
         if (m2_ff[b]) lz2 = 6'(40 - b);
      end
   end
   assign xs2 = CW'(dx2_ff) <<< lz2;
   assign ys2 = CW'(dy2_ff) <<< lz2;
   always_comb begin
      xr2 = xs2;
      yr2 = ys2;
      z2 = '0;
      if (xs2 < 0) begin
         if (ys2 >= 0) begin
            xr2 = ys2; yr2 = -xs2; z2 = gtg_pkg::HALF_PI_Q30;
         end else begin
            xr2 = -ys2; yr2 = xs2; z2 = -gtg_pkg::HALF_PI_Q30;
         end
      end
   end

   logic v3_ff;
   logic signed [CW-1:0] x3_ff, y3_ff;
   logic signed [ZW-1:0] z3_ff;
   gtg_pkg::side_type side3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
      if (advance) begin
         x3_ff <= xr2;
         y3_ff <= yr2;
         z3_ff <= z2;
         side3_ff <= '{near: near2, gain: gain_ff, speed: speed_ff, heading: hd2_ff};
      end
   end

   // bearing pipeline
   logic vc;
   logic signed [ZW-1:0] zc;
   gtg_pkg::side_type sc;
   gtg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v3_ff), .in_x(x3_ff), .in_y(y3_ff), .in_z(z3_ff), .in_side(side3_ff),
      .out_valid(vc), .out_z(zc), .out_side(sc)
   );

   // stage: error and wrap into (-pi, pi]
   logic signed [ZW+1:0] e0, ew;
   localparam logic signed [ZW+1:0] PI_W = (ZW+2)'(gtg_pkg::PI_Q30);
   assign e0 = (ZW+2)'(zc) - ((ZW+2)'(sc.heading) <<< 17);
   always_comb begin
      ew = e0;
      if (e0 > PI_W) ew = e0 - 2 * PI_W;
      else if (e0 <= -PI_W) ew = e0 + 2 * PI_W;
   end

   logic ve_ff;
   logic signed [ZW-1:0] e_ff;
   gtg_pkg::side_type se_ff;
   always_ff @(posedge clock) begin
      if (reset) ve_ff <= 1'b0;
      else if (advance) ve_ff <= vc;
      if (advance) begin
         e_ff <= ZW'(ew);
         se_ff <= sc;
      end
   end

   // stage: gain times error
   logic vp_ff;
   logic signed [50:0] p_ff;
   gtg_pkg::side_type sp_ff;
   always_ff @(posedge clock) begin
      if (reset) vp_ff <= 1'b0;
      else if (advance) vp_ff <= ve_ff;
      if (advance) begin
         p_ff <= 51'(e_ff) * $signed({35'd0, se_ff.gain});
         sp_ff <= se_ff;
      end
   end

   // output register: round, saturate, arrival override
   logic signed [50:0] rnd;
   logic signed [21:0] rq;
   logic signed [15:0] sat;
   assign rnd = p_ff + 51'sd268435456;
   assign rq = rnd[50:29];
   always_comb begin
      if (rq > 22'sd32767) sat = 16'sh7fff;
      else if (rq < -22'sd32768) sat = -16'sh8000;
      else sat = rq[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (advance) out_valid_ff <= vp_ff;
      if (advance) begin
         rsp_arrived <= sp_ff.near;
         rsp_linear_cmd <= sp_ff.near ? 16'd0 : sp_ff.speed;
         rsp_angular_cmd <= sp_ff.near ? 16'sd0 : sat;
      end
   end
   assign rsp_valid = out_valid_ff;

   // checks
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angular_cmd))
      else $error("result changed while stalled");
   a_arrived_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arrived |-> rsp_linear_cmd == 16'd0 && rsp_angular_cmd == 16'sd0)
      else $error("drive not zero on arrival");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");
endmodule

>>> rtl/core/gtg_cordic.sv
// gtg_cordic: pipelined vectoring cordic, one register stage per step.
// Depends on gtg_pkg for widths and the arctangent table.
module gtg_cordic #(
   parameter int STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic signed [gtg_pkg::CW-1:0] in_x,
   input  logic signed [gtg_pkg::CW-1:0] in_y,
   input  logic signed [gtg_pkg::ZW-1:0] in_z,
   input  gtg_pkg::side_type in_side,
   output logic out_valid,
   output logic signed [gtg_pkg::ZW-1:0] out_z,
   output gtg_pkg::side_type out_side
);
   localparam int N = (STEPS < gtg_pkg::ATAN_LEN) ? STEPS : gtg_pkg::ATAN_LEN;

   logic signed [gtg_pkg::CW-1:0] x_ff [1:N];
   logic signed [gtg_pkg::CW-1:0] y_ff [1:N];
   logic signed [gtg_pkg::ZW-1:0] z_ff [1:N];
   gtg_pkg::side_type side_ff [1:N];
   logic vld_ff [1:N];

   // one micro-rotation per stage, arithmetic shift is a floor shift
   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [gtg_pkg::CW-1:0] x_cur, y_cur;
      logic signed [gtg_pkg::ZW-1:0] z_cur;
      gtg_pkg::side_type side_cur;
      logic vld_cur;

      // stage input: the pipeline entry or the previous stage
      if (i == 0) begin : g_first
         assign x_cur = in_x;
         assign y_cur = in_y;
         assign z_cur = in_z;
         assign side_cur = in_side;
         assign vld_cur = in_valid;
      end else begin : g_next
         assign x_cur = x_ff[i];
         assign y_cur = y_ff[i];
         assign z_cur = z_ff[i];
         assign side_cur = side_ff[i];
         assign vld_cur = vld_ff[i];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[i+1] <= vld_cur;
         end
         if (advance) begin
            side_ff[i+1] <= side_cur;
            if (y_cur > 0) begin
               x_ff[i+1] <= x_cur + (y_cur >>> i);
               y_ff[i+1] <= y_cur - (x_cur >>> i);
               z_ff[i+1] <= z_cur + gtg_pkg::atan_q30(i);
            end else begin
               x_ff[i+1] <= x_cur - (y_cur >>> i);
               y_ff[i+1] <= y_cur + (x_cur >>> i);
               z_ff[i+1] <= z_cur - gtg_pkg::atan_q30(i);
            end
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_z = z_ff[N];
   assign out_side = side_ff[N];
endmodule

>>> test/go_to_goal_heading_controller_top_tb.sv
// Self-checking testbench for go_to_goal_heading_controller_top: predicts each
// command from its own atan2 and gain model and compares it with the block.
// Depends on gtg_pkg and the controller RTL.
module go_to_goal_heading_controller_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int STEPS = gtg_pkg::CORDIC_STEPS_DEF;
   localparam int LATENCY = STEPS + 6;
   localparam int IDLE_LIMIT = 2000;
   localparam longint PI_ANGLE = 64'sd3373259426;
   localparam logic signed [15:0] HEADING_MAX = 16'sd25736;

   typedef struct packed {
      logic [15:0]        linear;
      logic signed [15:0] angular;
      logic               arrived;
   } command_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [15:0] req_heading = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_linear_cmd;
   logic signed [15:0] rsp_angular_cmd;
   logic rsp_arrived;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_write_data = '0;

   // controller settings as the block should hold them
   logic signed [31:0] goal_x;
   logic signed [31:0] goal_y;
   logic [15:0] heading_gain;
   logic [15:0] cruise_speed;
   logic [15:0] arrive_radius;

   command_type pending_commands[$];
   int error_count = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit calm = 0;

   longint arctan_steps[24] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

   go_to_goal_heading_controller_top i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected command for one odometry request
   function automatic command_type predict_command(logic signed [31:0] px,
         logic signed [31:0] py, logic signed [15:0] hd);
      longint dx, dy, ax, ay, r, m, x, y, z, t, xs, ys, e, rate;
      command_type c;
      dx = longint'(goal_x) - longint'(px);
      dy = longint'(goal_y) - longint'(py);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      r = longint'(arrive_radius);
      if (ax <= r && ay <= r && ax * ax + ay * ay <= r * r) begin
         c.linear = '0;
         c.angular = '0;
         c.arrived = 1'b1;
         return c;
      end
      // normalise so the larger component reaches 2^40
      m = ax > ay ? ax : ay;
      x = dx;
      y = dy;
      while (m < (longint'(1) << 40)) begin
         m = m * 2;
         x = x * 2;
         y = y * 2;
      end
      z = 0;
      // fold the left half plane into the right
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = PI_ANGLE / 2;
         end else begin
            x = -y; y = t; z = -(PI_ANGLE / 2);
         end
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + arctan_steps[i];
         end else begin
            x = x - ys; y = y + xs; z = z - arctan_steps[i];
         end
      end
      // yaw error wrapped into (-pi, pi]
      e = z - longint'(hd) * 131072;
      while (e > PI_ANGLE) e = e - 2 * PI_ANGLE;
      while (e <= -PI_ANGLE) e = e + 2 * PI_ANGLE;
      rate = (longint'(heading_gain) * e + (longint'(1) << 28)) >>> 29;
      if (rate > 32767) rate = 32767;
      if (rate < -32768) rate = -32768;
      c.linear = cruise_speed;
      c.angular = rate[15:0];
      c.arrived = 1'b0;
      return c;
   endfunction

   // one register write, called at a falling edge, leaves the enable high
   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         gtg_pkg::REG_GOAL_X: goal_x = data;
         gtg_pkg::REG_GOAL_Y: goal_y = data;
         gtg_pkg::REG_GAIN:   heading_gain = data[15:0];
         gtg_pkg::REG_SPEED:  cruise_speed = data[15:0];
         gtg_pkg::REG_RADIUS: arrive_radius = data[15:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // full register set, with junk in the upper bits of the narrow ones
   task automatic configure(logic [31:0] gx, logic [31:0] gy, logic [15:0] gain,
         logic [15:0] speed, logic [15:0] radius);
      write_reg(gtg_pkg::REG_GOAL_X, gx);
      write_reg(gtg_pkg::REG_GOAL_Y, gy);
      write_reg(gtg_pkg::REG_GAIN, {16'($urandom_range(0, 65535)), gain});
      write_reg(gtg_pkg::REG_SPEED, {16'($urandom_range(0, 65535)), speed});
      write_reg(gtg_pkg::REG_RADIUS, {16'($urandom_range(0, 65535)), radius});
      write_reg(REG_UNUSED, $urandom);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // let every outstanding command come back, then the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // send one odometry request, called at a falling edge
   task automatic send_odometry(logic signed [31:0] px, logic signed [31:0] py,
         logic signed [15:0] hd);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_heading <= hd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_commands = {pending_commands, predict_command(px, py, hd)};
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] random_heading();
      if ($urandom_range(0, 5) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 2 * HEADING_MAX) - HEADING_MAX);
   endfunction

   // random positions: around the arrival circle, mid range or anywhere
   task automatic random_requests(int n);
      int kind, reach;
      logic signed [31:0] px, py;
      for (int k = 0; k < n; k++) begin
         kind = $urandom_range(0, 9);
         reach = 2 * arrive_radius + 2;
         if (kind < 4) begin
            px = goal_x - ($urandom_range(0, 2 * reach) - reach);
            py = goal_y - ($urandom_range(0, 2 * reach) - reach);
         end else if (kind < 7) begin
            px = goal_x + ($urandom_range(0, 1 << 21) - (1 << 20));
            py = goal_y + ($urandom_range(0, 1 << 21) - (1 << 20));
         end else begin
            px = $urandom;
            py = $urandom;
         end
         send_odometry(px, py, random_heading());
      end
   endtask

   task automatic test_reset_values();
      send_odometry(0, 0, 0);
      send_odometry(6554, 0, 0);
      send_odometry(6555, 0, 0);
      send_odometry(-65536, 65536, 12000);
      drain();
   endtask

   task automatic test_directed();
      // exact target with zero radius, then the boundary of a large radius
      configure(32'h7FFF_FFFF, 32'h8000_0000, 16'd4096, 16'd1234, 16'd0);
      send_odometry(32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_odometry(32'h8000_0000, 32'h7FFF_FFFF, HEADING_MAX);
      send_odometry(32'h7FFF_FFFF, 32'h7FFF_FFFF, -HEADING_MAX);
      drain();
      configure(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_odometry(-65535, 0, 0);
      send_odometry(-65536, 0, 0);
      send_odometry(-46341, -46341, 0);
      send_odometry(46340, 46340, 0);
      // each quadrant, the negative x axis, and headings beyond pi
      send_odometry(-200000, -300000, 16'sh7FFF);
      send_odometry(200000, -300000, 16'sh8000);
      send_odometry(200000, 300000, HEADING_MAX);
      send_odometry(-200000, 300000, -HEADING_MAX);
      send_odometry(500000, 0, 0);
      send_odometry(500000, 0, 16'sh8000);
      send_odometry(0, 500000, 0);
      send_odometry(0, -500000, 0);
      drain();
      configure(0, 0, 16'd0, 16'd0, 16'd0);
      send_odometry(32'h8000_0000, 32'h8000_0000, 16'sh7FFF);
      send_odometry(1, 0, 0);
      send_odometry(0, -1, 0);
      drain();
   endtask

   // several settings, one of them with neither side idling
   task automatic test_random();
      for (int phase = 0; phase < 6; phase++) begin
         calm = (phase == 2);
         case (phase)
            0: configure($urandom, $urandom, 16'($urandom), 16'($urandom),
                  16'($urandom));
            1: configure(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: configure($urandom, $urandom, 16'd0, 16'd0, 16'd0);
            default: configure($urandom_range(0, 1 << 22) - (1 << 21), $urandom,
                  16'($urandom_range(0, 16384)), 16'($urandom),
                  16'($urandom_range(0, 20000)));
         endcase
         random_requests(150);
         // hold the sender until the pipeline has emptied
         drain();
         random_requests(150);
         drain();
      end
      calm = 0;
   endtask

   initial begin
      goal_x = 0;
      goal_y = 0;
      heading_gain = 16'd2048;
      cruise_speed = 16'd9830;
      arrive_radius = 16'd6554;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_values();
      test_directed();
      test_random();
      repeat (LATENCY + 10) @(negedge clock);
      if (error_count == 0 && pending_commands.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side stalls, drawn per command
   always @(negedge clock) begin
      if (reset || stall_left > 0) begin
         rsp_ready <= 1'b0;
         if (!reset) stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each command with the oldest prediction
   always @(posedge clock) begin
      command_type exp_cmd;
      if (!reset && rsp_valid && rsp_ready) begin
         stall_left <= calm ? 0 : $urandom_range(0, 7);
         if (pending_commands.size() == 0) begin
            $display("%0t: command with no request outstanding", $time);
            error_count++;
         end else begin
            exp_cmd = pending_commands.pop_front();
            if (rsp_linear_cmd !== exp_cmd.linear) begin
               $display("%0t: linear_cmd expected %0d actual %0d", $time,
                  exp_cmd.linear, rsp_linear_cmd);
               error_count++;
            end
            if (rsp_angular_cmd !== exp_cmd.angular) begin
               $display("%0t: angular_cmd expected %0d actual %0d", $time,
                  exp_cmd.angular, rsp_angular_cmd);
               error_count++;
            end
            if (rsp_arrived !== exp_cmd.arrived) begin
               $display("%0t: arrived expected %0d actual %0d", $time,
                  exp_cmd.arrived, rsp_arrived);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
